@@ rtl/online_bridge_counter_assert.svh @@
// assertion helpers for the checker file
`ifndef ONLINE_BRIDGE_COUNTER_ASSERT_SVH
`define ONLINE_BRIDGE_COUNTER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define OLBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("olbc check failed");

// consequent must hold in the cycle after the antecedent
`define OLBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("olbc check failed");

`endif

@@ rtl/olbc_pkg.sv @@
`default_nettype none
package olbc_pkg;

  localparam int unsigned VtxW           = 16;
  localparam int unsigned NumW           = 17;
  localparam int unsigned CountW         = 16;
  localparam int unsigned CntW           = 32;
  localparam int unsigned MaxVerticesDef = 65536;
  localparam logic [NumW-1:0] NumReset   = 17'd65536;

  localparam logic OpClear = 1'b0;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_SWEEP,
    OP_START,
    OP_CL_SEL,
    OP_FIND,
    OP_CL_UPD,
    OP_FO_SEL,
    OP_FO_CHK,
    OP_SZ_A,
    OP_SZ_B,
    OP_SZ_CMP,
    OP_RR_WR,
    OP_LINK,
    OP_DONE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic sweep_all;
  } cmd_t;

  typedef struct packed {
    logic find_done;
    logic clear;
    logic bad;
    logic cnt_wrap;
    logic pos_a_ok;
    logic pos_b_ok;
    logic meet_hit;
    logic cur_is_meet;
    logic fside_b;
    logic par_none;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ rtl/online_bridge_counter.sv @@
// channel   direction  handshake                 payload
// in        sink       in_valid_i / in_stall_o   opcode_i, vertex_a_i, vertex_b_i
// out       source     out_valid_o / out_stall_i bridge_count_o, bad_vertex_o
// cfg       sink       cfg_we_i                  cfg_wdata_i (num_vertices)
//
// one request at a time; each takes a data dependent time, set by the leader chain
// walks in the leader memory (one hop a cycle) and the tree climbs, where each climbed
// node costs a select and an update step on top of its hops.
// after reset and for a clear request, a sweep of all MaxVertices entries resets the tables.
// a stamp counter wrap (counter at its 32-bit top value) costs one extra sweep of all stamps.
// a finished result waits in the output register while the next request is accepted.
`default_nettype none
module online_bridge_counter #(
  parameter int unsigned MaxVertices = olbc_pkg::MaxVerticesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [olbc_pkg::NumW-1:0]    cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         opcode_i,
  input  wire logic [olbc_pkg::VtxW-1:0]    vertex_a_i,
  input  wire logic [olbc_pkg::VtxW-1:0]    vertex_b_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [olbc_pkg::CountW-1:0]  bridge_count_o,
  output logic                              bad_vertex_o
);
  import olbc_pkg::*;

  cmd_t    cmd;
  status_t st;

  olbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .st_i(st), .cmd_o(cmd)
  );

  olbc_datapath #(.MaxVertices(MaxVertices)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .opcode_i, .vertex_a_i, .vertex_b_i,
    .out_valid_o, .out_stall_i, .bridge_count_o, .bad_vertex_o,
    .cmd_i(cmd), .st_o(st)
  );

endmodule
`default_nettype wire

@@ rtl/olbc_ram.sv @@
`default_nettype none
module olbc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/olbc_ctrl.sv @@
`default_nettype none
module olbc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire olbc_pkg::status_t st_i,
  output olbc_pkg::cmd_t         cmd_o
);
  import olbc_pkg::*;

  typedef enum logic [15:0] {
    S_SWEEP   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_START   = 16'h0004,
    S_CL_SEL  = 16'h0008,
    S_CL_FIND = 16'h0010,
    S_CL_UPD  = 16'h0020,
    S_FO_SEL  = 16'h0040,
    S_FO_FIND = 16'h0080,
    S_FO_CHK  = 16'h0100,
    S_SZ_A    = 16'h0200,
    S_SZ_B    = 16'h0400,
    S_SZ_CMP  = 16'h0800,
    S_RR_FIND = 16'h1000,
    S_RR_WR   = 16'h2000,
    S_LINK    = 16'h4000,
    S_DONE    = 16'h8000
  } state_e;

  state_e state_q, state_d, after_q, after_d;
  logic   sweep_all_q, sweep_all_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    after_d       = after_q;
    sweep_all_d   = sweep_all_q;
    cmd_o.op        = OP_IDLE;
    cmd_o.sweep_all = sweep_all_q;
    unique case (state_q)
      S_SWEEP: begin
        cmd_o.op = OP_SWEEP;
        if (st_i.sweep_last) state_d = after_q;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = S_START;
        end
      end
      S_START: begin
        cmd_o.op = OP_START;
        if (st_i.clear) begin
          sweep_all_d = 1'b1;
          after_d     = S_DONE;
          state_d     = S_SWEEP;
        end else if (st_i.bad) begin
          state_d = S_DONE;
        end else if (st_i.cnt_wrap) begin
          // stamp counter wrapped: wipe visit stamps only
          sweep_all_d = 1'b0;
          after_d     = S_CL_SEL;
          state_d     = S_SWEEP;
        end else begin
          state_d = S_CL_SEL;
        end
      end
      S_CL_SEL: begin
        if (!st_i.pos_a_ok && !st_i.pos_b_ok) begin
          state_d = S_SZ_A;
        end else begin
          cmd_o.op = OP_CL_SEL;
          state_d  = S_CL_FIND;
        end
      end
      S_CL_FIND: begin
        cmd_o.op = OP_FIND;
        if (st_i.find_done) state_d = S_CL_UPD;
      end
      S_CL_UPD: begin
        cmd_o.op = OP_CL_UPD;
        state_d  = st_i.meet_hit ? S_FO_SEL : S_CL_SEL;
      end
      S_FO_SEL: begin
        cmd_o.op = OP_FO_SEL;
        state_d  = S_FO_FIND;
      end
      S_FO_FIND: begin
        cmd_o.op = OP_FIND;
        if (st_i.find_done) state_d = S_FO_CHK;
      end
      S_FO_CHK: begin
        cmd_o.op = OP_FO_CHK;
        if (st_i.cur_is_meet) begin
          state_d = st_i.fside_b ? S_DONE : S_FO_SEL;
        end else begin
          state_d = S_FO_FIND;
        end
      end
      S_SZ_A: begin
        cmd_o.op = OP_SZ_A;
        state_d  = S_SZ_B;
      end
      S_SZ_B: begin
        cmd_o.op = OP_SZ_B;
        state_d  = S_SZ_CMP;
      end
      S_SZ_CMP: begin
        cmd_o.op = OP_SZ_CMP;
        state_d  = S_RR_FIND;
      end
      S_RR_FIND: begin
        cmd_o.op = OP_FIND;
        if (st_i.find_done) state_d = S_RR_WR;
      end
      S_RR_WR: begin
        cmd_o.op = OP_RR_WR;
        state_d  = st_i.par_none ? S_LINK : S_RR_FIND;
      end
      S_LINK: begin
        cmd_o.op = OP_LINK;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.op = OP_DONE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      after_q     <= S_IDLE;
      sweep_all_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      after_q     <= after_d;
      sweep_all_q <= sweep_all_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/olbc_datapath.sv @@
`default_nettype none
module olbc_datapath #(
  parameter int unsigned MaxVertices = olbc_pkg::MaxVerticesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [olbc_pkg::NumW-1:0]    cfg_wdata_i,
  input  wire logic                         opcode_i,
  input  wire logic [olbc_pkg::VtxW-1:0]    vertex_a_i,
  input  wire logic [olbc_pkg::VtxW-1:0]    vertex_b_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [olbc_pkg::CountW-1:0]  bridge_count_o,
  output logic                              bad_vertex_o,
  input  wire olbc_pkg::cmd_t               cmd_i,
  output olbc_pkg::status_t                 st_o
);
  import olbc_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxVertices);
  localparam int unsigned PosW = IdxW + 1;
  localparam int unsigned CmpW = (PosW > NumW) ? PosW : NumW;
  localparam int unsigned SatW = (PosW > CountW) ? PosW : CountW;
  localparam logic [PosW-1:0] NonePos = PosW'(MaxVertices);
  localparam logic [CmpW-1:0] MaxCmp  = CmpW'(MaxVertices);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxVertices - 1);

  // registers
  logic [NumW-1:0]   num_q, num_d;
  logic              op_q, op_d;
  logic [VtxW-1:0]   va_q, va_d, vb_q, vb_d;
  logic [PosW-1:0]   pos_a_q, pos_a_d, pos_b_q, pos_b_d;
  logic [PosW-1:0]   root_a_q, root_a_d, root_b_q, root_b_d;
  logic [PosW-1:0]   meet_q, meet_d, cur_q, cur_d, fstart_q, fstart_d;
  logic [PosW-1:0]   below_q, below_d, top_q, top_d, link_q, link_d;
  logic [PosW-1:0]   size_a_q, size_a_d;
  logic              side_q, side_d, csel_q, csel_d, fside_q, fside_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PosW-1:0]   bridges_q, bridges_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              bad_q, bad_d;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] out_cnt_q, out_cnt_d;
  logic              out_bad_q, out_bad_d;

  // memory ports
  logic            lead_we, par_we, size_we, stamp_we;
  logic [IdxW-1:0] lead_wa, lead_ra, par_wa, size_wa, size_ra, stamp_wa;
  logic [IdxW-1:0] lead_wd, lead_rd;
  logic [PosW-1:0] par_wd, par_rd, size_wd, size_rd;
  logic [CntW-1:0] stamp_wd, stamp_rd;

  logic [CmpW-1:0] nv_eff;
  logic [PosW-1:0] va_pos, vb_pos, find_v;
  logic            find_go, edge_bad, use_b, swap;
  logic [SatW-1:0] br_ext;
  logic [CountW-1:0] br_sat;

  assign nv_eff   = (CmpW'(num_q) > MaxCmp) ? MaxCmp : CmpW'(num_q);
  assign edge_bad = (CmpW'(va_q) >= nv_eff) || (CmpW'(vb_q) >= nv_eff);
  assign va_pos   = PosW'(va_q);
  assign vb_pos   = PosW'(vb_q);
  assign use_b    = side_q ? (pos_b_q != NonePos) : (pos_a_q == NonePos);
  assign swap     = size_a_q > size_rd;
  assign br_ext   = SatW'(bridges_q);
  assign br_sat   = (br_ext > SatW'({CountW{1'b1}})) ? {CountW{1'b1}} : CountW'(br_ext);

  assign st_o.find_done   = (PosW'(lead_rd) == cur_q);
  assign st_o.clear       = (op_q == OpClear);
  assign st_o.bad         = edge_bad;
  assign st_o.cnt_wrap    = (cnt_q == {CntW{1'b1}});
  assign st_o.pos_a_ok    = (pos_a_q != NonePos);
  assign st_o.pos_b_ok    = (pos_b_q != NonePos);
  assign st_o.meet_hit    = (stamp_rd == cnt_q);
  assign st_o.cur_is_meet = (cur_q == meet_q);
  assign st_o.fside_b     = fside_q;
  assign st_o.par_none    = (par_rd == NonePos);
  assign st_o.sweep_last  = (idx_q == LastIdx);
  assign st_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign bridge_count_o = out_cnt_q;
  assign bad_vertex_o   = out_bad_q;

  always_comb begin
    num_d = num_q;     op_d = op_q;       va_d = va_q;         vb_d = vb_q;
    pos_a_d = pos_a_q; pos_b_d = pos_b_q; root_a_d = root_a_q; root_b_d = root_b_q;
    meet_d = meet_q;   cur_d = cur_q;     fstart_d = fstart_q;
    below_d = below_q; top_d = top_q;     link_d = link_q;     size_a_d = size_a_q;
    side_d = side_q;   csel_d = csel_q;   fside_d = fside_q;
    cnt_d = cnt_q;     bridges_d = bridges_q; idx_d = idx_q;   bad_d = bad_q;
    out_valid_d = out_valid_q; out_cnt_d = out_cnt_q; out_bad_d = out_bad_q;

    lead_we  = 1'b0; lead_wa = fstart_q[IdxW-1:0]; lead_wd = cur_q[IdxW-1:0];
    lead_ra  = cur_q[IdxW-1:0];
    par_we   = 1'b0; par_wa = cur_q[IdxW-1:0]; par_wd = below_q;
    size_we  = 1'b0; size_wa = root_b_q[IdxW-1:0]; size_wd = size_a_q;
    size_ra  = root_b_q[IdxW-1:0];
    stamp_we = 1'b0; stamp_wa = cur_q[IdxW-1:0]; stamp_wd = cnt_q;
    find_go  = 1'b0; find_v = cur_q;

    if (cfg_we_i) num_d = cfg_wdata_i;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (cmd_i.op)
      OP_IDLE: ;
      OP_ACCEPT: begin
        op_d = opcode_i;
        va_d = vertex_a_i;
        vb_d = vertex_b_i;
      end
      OP_SWEEP: begin
        lead_we  = cmd_i.sweep_all; lead_wa = idx_q; lead_wd = idx_q;
        par_we   = cmd_i.sweep_all; par_wa = idx_q;  par_wd = NonePos;
        size_we  = cmd_i.sweep_all; size_wa = idx_q; size_wd = PosW'(1);
        stamp_we = 1'b1; stamp_wa = idx_q; stamp_wd = '0;
        idx_d    = (idx_q == LastIdx) ? '0 : idx_q + IdxW'(1);
      end
      OP_START: begin
        bad_d = (op_q != OpClear) && edge_bad;
        if (op_q == OpClear) begin
          bridges_d = '0;
          cnt_d     = '0;
        end else if (!edge_bad) begin
          cnt_d    = (cnt_q == {CntW{1'b1}}) ? CntW'(1) : cnt_q + CntW'(1);
          pos_a_d  = va_pos;
          pos_b_d  = vb_pos;
          side_d   = 1'b0;
          fside_d  = 1'b0;
          meet_d   = NonePos;
          root_a_d = NonePos;
          root_b_d = NonePos;
        end
      end
      OP_CL_SEL: begin
        csel_d  = use_b;
        find_go = 1'b1;
        find_v  = use_b ? pos_b_q : pos_a_q;
      end
      OP_FIND: begin
        if (PosW'(lead_rd) == cur_q) begin
          // shortcut the start of the chain to its leader
          lead_we = (fstart_q != cur_q);
        end else begin
          cur_d   = PosW'(lead_rd);
          lead_ra = lead_rd;
        end
      end
      OP_CL_UPD: begin
        stamp_we = 1'b1;
        if (stamp_rd == cnt_q) meet_d = cur_q;
        if (csel_q) begin
          pos_b_d = par_rd;
          if (par_rd == NonePos) root_b_d = cur_q;
        end else begin
          pos_a_d = par_rd;
          if (par_rd == NonePos) root_a_d = cur_q;
        end
        side_d = !csel_q;
      end
      OP_FO_SEL: begin
        find_go = 1'b1;
        find_v  = fside_q ? vb_pos : va_pos;
      end
      OP_FO_CHK: begin
        if (cur_q == meet_q) begin
          fside_d = 1'b1;
        end else begin
          lead_we = 1'b1;
          lead_wa = cur_q[IdxW-1:0];
          lead_wd = meet_q[IdxW-1:0];
          if (bridges_q != '0) bridges_d = bridges_q - PosW'(1);
          find_go = 1'b1;
          find_v  = par_rd;
        end
      end
      OP_SZ_A: size_ra = root_a_q[IdxW-1:0];
      OP_SZ_B: size_a_d = size_rd;
      OP_SZ_CMP: begin
        // smaller tree is re-rooted and hung below the other endpoint
        size_we   = 1'b1;
        size_wa   = swap ? root_a_q[IdxW-1:0] : root_b_q[IdxW-1:0];
        size_wd   = PosW'(size_a_q + size_rd);
        bridges_d = bridges_q + PosW'(1);
        below_d   = NonePos;
        link_d    = swap ? va_pos : vb_pos;
        find_go   = 1'b1;
        find_v    = swap ? vb_pos : va_pos;
      end
      OP_RR_WR: begin
        par_we  = 1'b1;
        if (below_q == NonePos) top_d = cur_q;
        below_d = cur_q;
        if (par_rd != NonePos) begin
          find_go = 1'b1;
          find_v  = par_rd;
        end
      end
      OP_LINK: begin
        par_we = 1'b1;
        par_wa = top_q[IdxW-1:0];
        par_wd = link_q;
      end
      OP_DONE: begin
        out_valid_d = 1'b1;
        out_cnt_d   = br_sat;
        out_bad_d   = bad_q;
      end
      default: ;
    endcase

    if (find_go) begin
      cur_d    = find_v;
      fstart_d = find_v;
      lead_ra  = find_v[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= NumReset;
      cnt_q       <= '0;
      bridges_q   <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      num_q       <= num_d;
      cnt_q       <= cnt_d;
      bridges_q   <= bridges_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;     va_q     <= va_d;     vb_q     <= vb_d;
    pos_a_q  <= pos_a_d;  pos_b_q  <= pos_b_d;
    root_a_q <= root_a_d; root_b_q <= root_b_d;
    meet_q   <= meet_d;   cur_q    <= cur_d;    fstart_q <= fstart_d;
    below_q  <= below_d;  top_q    <= top_d;    link_q   <= link_d;
    size_a_q <= size_a_d;
    side_q   <= side_d;   csel_q   <= csel_d;   fside_q  <= fside_d;
    bad_q    <= bad_d;    out_cnt_q <= out_cnt_d; out_bad_q <= out_bad_d;
  end

  olbc_ram #(.Width(IdxW), .Depth(MaxVertices)) u_lead_ram (
    .clk_i, .we_i(lead_we), .waddr_i(lead_wa), .wdata_i(lead_wd),
    .raddr_i(lead_ra), .rdata_o(lead_rd)
  );

  olbc_ram #(.Width(PosW), .Depth(MaxVertices)) u_parent_ram (
    .clk_i, .we_i(par_we), .waddr_i(par_wa), .wdata_i(par_wd),
    .raddr_i(cur_q[IdxW-1:0]), .rdata_o(par_rd)
  );

  olbc_ram #(.Width(PosW), .Depth(MaxVertices)) u_size_ram (
    .clk_i, .we_i(size_we), .waddr_i(size_wa), .wdata_i(size_wd),
    .raddr_i(size_ra), .rdata_o(size_rd)
  );

  olbc_ram #(.Width(CntW), .Depth(MaxVertices)) u_stamp_ram (
    .clk_i, .we_i(stamp_we), .waddr_i(stamp_wa), .wdata_i(stamp_wd),
    .raddr_i(cur_q[IdxW-1:0]), .rdata_o(stamp_rd)
  );

endmodule
`default_nettype wire

@@ rtl/olbc_checker.sv @@
`default_nettype none
`include "online_bridge_counter_assert.svh"
module olbc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [olbc_pkg::CountW-1:0]  bridge_count_o,
  input wire logic                         bad_vertex_o
);

  // a held result keeps its value
  `OLBC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(bridge_count_o) && $stable(bad_vertex_o))

  // an accepted request keeps the block busy
  `OLBC_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)

  // a new result only appears at the end of work
  `OLBC_ASSERT_NOW(a_result_after_work, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind online_bridge_counter olbc_checker u_olbc_checker (.*);
`default_nettype wire

@@ bench/online_bridge_counter_test.sv @@
`default_nettype none
module online_bridge_counter_test;
  import olbc_pkg::*;

  localparam int unsigned VtxCap   = MaxVerticesDef;
  localparam int unsigned Nil      = VtxCap;
  localparam int unsigned CycLimit = 3000000;

  typedef struct packed {
    logic            op;
    logic [VtxW-1:0] a;
    logic [VtxW-1:0] b;
  } edge_req_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              bad;
  } bridge_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [NumW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              opcode_i = 1'b0;
  logic [VtxW-1:0]   vertex_a_i = '0;
  logic [VtxW-1:0]   vertex_b_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CountW-1:0] bridge_count_o;
  logic              bad_vertex_o;

  online_bridge_counter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bridge_count_o (bridge_count_o),
    .bad_vertex_o   (bad_vertex_o)
  );

  // shadow of the bridge forest
  int unsigned tree_up [VtxCap];
  int unsigned tec_lead[VtxCap];
  int unsigned cc_lead [VtxCap];
  int unsigned cc_size [VtxCap];
  int unsigned seen_at [VtxCap];
  int unsigned trail_a [VtxCap];
  int unsigned trail_b [VtxCap];
  int unsigned visit_no;
  int unsigned bridges;
  int unsigned nv_eff = VtxCap;

  edge_req_t   pending_reqs[$];
  bridge_res_t expected_counts[$];
  edge_req_t   cur_req;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned cycles = 0;
  int unsigned pushed_n = 0;
  int unsigned done_n = 0;
  bit          calm = 0;
  bit          failed = 0;

  function automatic void clear_forest();
    for (int unsigned i = 0; i < VtxCap; i++) begin
      tree_up[i] = Nil;
      tec_lead[i] = i;
      cc_lead[i] = i;
      cc_size[i] = 1;
      seen_at[i] = 0;
    end
    visit_no = 0;
    bridges = 0;
  endfunction

  function automatic int unsigned find_tec(int unsigned v);
    int unsigned r, nx;
    if (v >= Nil) return Nil;
    r = v;
    while (tec_lead[r] != r) r = tec_lead[r];
    while (v != r) begin
      nx = tec_lead[v];
      tec_lead[v] = r;
      v = nx;
    end
    return r;
  endfunction

  function automatic int unsigned find_cc(int unsigned v);
    int unsigned r, x, nx;
    r = find_tec(v);
    if (r >= Nil) return Nil;
    while (cc_lead[r] != r) r = find_tec(cc_lead[r]);
    x = find_tec(v);
    while (x != r) begin
      nx = find_tec(cc_lead[x]);
      cc_lead[x] = r;
      x = nx;
    end
    return r;
  endfunction

  function automatic void flip_tree(int unsigned v);
    int unsigned top, below, up;
    v = find_tec(v);
    if (v >= Nil) return;
    top = v;
    below = Nil;
    while (v < Nil) begin
      up = find_tec(tree_up[v]);
      tree_up[v] = below;
      cc_lead[v] = top;
      below = v;
      v = up;
    end
    cc_size[top] = cc_size[below];
  endfunction

  function automatic void close_cycle(int unsigned a, int unsigned b);
    int unsigned meet, la, lb, x;
    meet = Nil;
    la = 0;
    lb = 0;
    visit_no++;
    if (visit_no == 0) begin
      for (int unsigned i = 0; i < VtxCap; i++) seen_at[i] = 0;
      visit_no = 1;
    end
    while (meet == Nil) begin
      if (a < Nil) begin
        x = find_tec(a);
        if (x >= Nil) a = Nil;
        else begin
          if (la < VtxCap) begin trail_a[la] = x; la++; end
          if (seen_at[x] == visit_no) meet = x;
          seen_at[x] = visit_no;
          a = tree_up[x];
        end
      end
      if (b < Nil) begin
        x = find_tec(b);
        if (x >= Nil) b = Nil;
        else begin
          if (lb < VtxCap) begin trail_b[lb] = x; lb++; end
          if (seen_at[x] == visit_no) meet = x;
          seen_at[x] = visit_no;
          b = tree_up[x];
        end
      end
      if (meet == Nil && a >= Nil && b >= Nil) return;
    end
    for (int unsigned i = 0; i < la; i++) begin
      tec_lead[trail_a[i]] = meet;
      if (trail_a[i] == meet) break;
      if (bridges > 0) bridges--;
    end
    for (int unsigned i = 0; i < lb; i++) begin
      tec_lead[trail_b[i]] = meet;
      if (trail_b[i] == meet) break;
      if (bridges > 0) bridges--;
    end
  endfunction

  function automatic void add_link(int unsigned a, int unsigned b);
    int unsigned ca, cb, t;
    a = find_tec(a);
    b = find_tec(b);
    if (a == b) return;
    ca = find_cc(a);
    cb = find_cc(b);
    if (ca != cb) begin
      bridges++;
      if (cc_size[ca] > cc_size[cb]) begin
        t = a; a = b; b = t;
        t = ca; ca = cb; cb = t;
      end
      flip_tree(a);
      tree_up[a] = b;
      cc_lead[a] = b;
      cc_size[cb] += cc_size[ca];
    end else begin
      close_cycle(a, b);
    end
  endfunction

  function automatic bridge_res_t predict_bridges(edge_req_t r);
    bridge_res_t res;
    res.bad = 1'b0;
    if (r.op == OpClear) clear_forest();
    else if (r.a >= nv_eff || r.b >= nv_eff) res.bad = 1'b1;
    else add_link(r.a, r.b);
    res.count = (bridges > 32'hFFFF) ? 16'hFFFF : bridges[CountW-1:0];
    return res;
  endfunction

  task automatic push_req(logic op, int unsigned a, int unsigned b);
    edge_req_t r;
    r.op = op;
    r.a = a[VtxW-1:0];
    r.b = b[VtxW-1:0];
    pending_reqs.insert(pending_reqs.size(), r);
    pushed_n++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (done_n != pushed_n);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_vertices(int unsigned val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val[NumW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    nv_eff = (val > VtxCap) ? VtxCap : val;
  endtask

  initial begin
    clear_forest();
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycLimit) begin
      $display("[online_bridge_counter] ERROR");
      $finish;
    end
  end

  // request driver
  always @(posedge clk_i) begin : drive
    logic v_next;
    if (rst_ni) begin
      v_next = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_counts.insert(expected_counts.size(), predict_bridges(cur_req));
        v_next = 1'b0;
        tx_wait = calm ? 0 : $urandom_range(0, 3);
      end
      if (!v_next) begin
        if (tx_wait > 0) tx_wait--;
        else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          opcode_i <= cur_req.op;
          vertex_a_i <= cur_req.a;
          vertex_b_i <= cur_req.b;
          v_next = 1'b1;
        end
      end
      in_valid_i <= v_next;
    end
  end

  // result monitor
  always @(posedge clk_i) begin : watch
    bridge_res_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_counts.size() == 0) begin
          $display("%0t unexpected result count %0d bad %0b", $time, bridge_count_o,
                   bad_vertex_o);
          failed = 1;
        end else begin
          exp_r = expected_counts.pop_front();
          if (bridge_count_o !== exp_r.count) begin
            $display("%0t bridge_count expected %0d actual %0d", $time, exp_r.count,
                     bridge_count_o);
            failed = 1;
          end
          if (bad_vertex_o !== exp_r.bad) begin
            $display("%0t bad_vertex expected %0b actual %0b", $time, exp_r.bad,
                     bad_vertex_o);
            failed = 1;
          end
        end
        done_n++;
        rx_wait = calm ? 0 : $urandom_range(0, 3);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned nv, r, a, b;
    int unsigned nv_list[6];
    nv_list = '{5, 12, 40, 200, 65536, 9};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: widest ids, self loop, cycle closing, repeat, clear, vertex count limits
    push_req(1'b1, 0, 65535);
    push_req(1'b1, 65535, 65535);
    push_req(1'b1, 0, 1);
    push_req(1'b1, 1, 65535);
    push_req(1'b1, 65535, 0);
    push_req(1'b1, 2, 3);
    push_req(1'b1, 3, 4);
    push_req(1'b1, 4, 2);
    push_req(1'b0, 65535, 43690);
    push_req(1'b1, 7, 8);
    set_vertices(0);
    push_req(1'b1, 0, 0);
    push_req(1'b1, 0, 65535);
    set_vertices(1);
    push_req(1'b1, 0, 0);
    push_req(1'b1, 0, 1);
    push_req(1'b1, 1, 0);
    set_vertices(131071);
    push_req(1'b1, 65535, 12345);
    push_req(1'b1, 21845, 65535);
    set_vertices(65537);
    push_req(1'b1, 32768, 8);

    for (int p = 0; p < 6; p++) begin
      nv = nv_list[p];
      set_vertices(nv);
      calm = (p == 2);
      for (int i = 0; i < 115; i++) begin
        if (i == 57 && (p % 2) == 1) push_req(OpClear, $urandom, $urandom);
        r = $urandom_range(0, 99);
        if (r < 6) begin
          a = $urandom_range(0, 65535);
          b = $urandom_range(0, 65535);
        end else begin
          a = $urandom_range(0, nv - 1);
          b = $urandom_range(0, nv - 1);
        end
        push_req(1'b1, a, b);
      end
      // hold the sender until the block has drained
      wait_idle();
    end
    calm = 0;

    wait_idle();
    repeat (64) @(posedge clk_i);
    if (!failed && expected_counts.size() == 0) begin
      $display("[online_bridge_counter] OK");
    end else begin
      $display("[online_bridge_counter] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
